>>> hdl/ifla_pkg.sv
// Shared definitions for the implicit free list allocator.
// Holds the controller-to-datapath operation codes and the status bundle.
// No dependencies.
`default_nettype none

package ifla_pkg;

  typedef logic [4:0] op_t;

  localparam op_t OP_NOP       = 5'd0;
  localparam op_t OP_INIT_WR   = 5'd1;
  localparam op_t OP_LOAD      = 5'd2;
  localparam op_t OP_WALK_RD   = 5'd3;
  localparam op_t OP_WALK_STEP = 5'd4;
  localparam op_t OP_EXT_W0    = 5'd5;
  localparam op_t OP_EXT_W1    = 5'd6;
  localparam op_t OP_EXT_W2    = 5'd7;
  localparam op_t OP_M_RD_HDR  = 5'd8;
  localparam op_t OP_M_RD_NEXT = 5'd9;
  localparam op_t OP_M_RD_PREV = 5'd10;
  localparam op_t OP_M_CALC    = 5'd11;
  localparam op_t OP_M_W0      = 5'd12;
  localparam op_t OP_M_W1      = 5'd13;
  localparam op_t OP_F_RD      = 5'd14;
  localparam op_t OP_F_CALC    = 5'd15;
  localparam op_t OP_S_W0      = 5'd16;
  localparam op_t OP_S_W1      = 5'd17;
  localparam op_t OP_S_W2      = 5'd18;
  localparam op_t OP_S_W3      = 5'd19;
  localparam op_t OP_A_W0      = 5'd20;
  localparam op_t OP_A_W1      = 5'd21;
  localparam op_t OP_FREE_CAP  = 5'd22;
  localparam op_t OP_FREE_W0   = 5'd23;
  localparam op_t OP_FREE_W1   = 5'd24;
  localparam op_t OP_DONE_OK   = 5'd25;
  localparam op_t OP_DONE_FAIL = 5'd26;
  localparam op_t OP_DONE_FREE = 5'd27;

  typedef struct packed {
    logic init_last;
    logic is_free;
    logic bp_in;
    logic bp_le_addr;
    logic bp_is_addr;
    logic rd_zero;
    logic rd_alloc;
    logic rd_fit;
    logic no_room;
    logic split;
  } dp_status_t;

endpackage

`default_nettype wire

>>> hdl/ifla_dp.sv
// Datapath of the allocator: heap word store, walk pointer, merge and split math.
// Executes one operation code per cycle from ifla_ctrl; uses ifla_pkg.
`default_nettype none

module ifla_dp #(
  parameter int HEAP_WORDS          = 4096,
  parameter int INITIAL_CHUNK_BYTES = 512
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ifla_pkg::op_t    op,
  input  wire logic             action,
  input  wire logic [14:0]      request_bytes,
  input  wire logic [13:0]      block_address,
  output ifla_pkg::dp_status_t  st,
  output logic                  done,
  output logic [13:0]           payload_address,
  output logic [14:0]           granted_bytes,
  output logic                  status
);

  localparam int IW = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;
  localparam int BW = (IW + 3 > 17) ? IW + 3 : 17;
  localparam int INIT_WORDS_RAW = INITIAL_CHUNK_BYTES / 4;
  localparam int INIT_WORDS = INIT_WORDS_RAW + (INIT_WORDS_RAW % 2);
  localparam int INIT_BSIZE = INIT_WORDS * 4 + 8;
  localparam bit INIT_FITS = (16 + INIT_BSIZE) <= HEAP_WORDS * 4;
  localparam int INIT_FOOT = 3 + INIT_BSIZE / 4 - 1;
  localparam int INIT_EPI = 3 + INIT_BSIZE / 4;
  localparam int INIT_END = INIT_FITS ? 16 + INIT_BSIZE : 16;

  localparam logic [BW-1:0] HW_C   = BW'(HEAP_WORDS);
  localparam logic [BW-1:0] LIMIT  = BW'(HEAP_WORDS * 4);
  localparam logic [BW-1:0] ONE    = BW'(1);
  localparam logic [BW-1:0] MIN_REM = BW'(16);

  function automatic logic [31:0] mk_tag(input logic [BW-1:0] sz, input logic a);
    return (32'(sz) << 3) | 32'(a);
  endfunction

  logic [31:0] mem [HEAP_WORDS];
  logic [31:0] mem_q;
  logic        rd_oob;
  logic [31:0] rdata;

  logic [BW-1:0] bp, need, heap_end, msize, nsize, fsize, start_w, total;
  logic          nfree;
  logic [13:0]   addr_q;
  logic          action_q;
  logic [IW-1:0] iidx;

  logic          wr_en;
  logic [BW-1:0] wr_idx;
  logic [31:0]   wr_data;
  logic [BW-1:0] rd_idx;
  logic [BW-1:0] rd_size;
  logic [BW-1:0] hdr;
  logic [BW-1:0] psize;
  logic          pfree;
  logic [31:0]   init_word;
  logic [15:0]   w0, w1;

  assign rdata   = rd_oob ? 32'd0 : mem_q;
  assign rd_size = rdata[BW+2:3];
  assign hdr     = {2'b00, bp[BW-1:2]} - ONE;
  assign psize   = rd_size;
  assign pfree   = ~rdata[0];
  assign w0      = (request_bytes < 15'd8) ? 16'd8 : {1'b0, request_bytes};
  assign w1      = (w0 + 16'd7) & ~16'd7;

  always_comb begin
    init_word = 32'd0;
    if (BW'(iidx) == BW'(0)) begin
      init_word = mk_tag('0, 1'b1);
    end else if (BW'(iidx) == BW'(1) || BW'(iidx) == BW'(2)) begin
      init_word = mk_tag(BW'(8), 1'b1);
    end else if (BW'(iidx) == BW'(3)) begin
      init_word = INIT_FITS ? mk_tag(BW'(INIT_BSIZE), 1'b0) : mk_tag('0, 1'b1);
    end else if (INIT_FITS && BW'(iidx) == BW'(INIT_FOOT)) begin
      init_word = mk_tag(BW'(INIT_BSIZE), 1'b0);
    end else if (INIT_FITS && BW'(iidx) == BW'(INIT_EPI)) begin
      init_word = mk_tag('0, 1'b1);
    end
  end

  // Store port selection for the current operation.
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = '0;
    wr_data = 32'd0;
    rd_idx  = hdr;
    case (op)
      ifla_pkg::OP_INIT_WR: begin
        wr_en = 1'b1; wr_idx = BW'(iidx); wr_data = init_word;
      end
      ifla_pkg::OP_EXT_W0: begin
        wr_en = 1'b1; wr_idx = {2'b00, heap_end[BW-1:2]} - ONE;
        wr_data = mk_tag(need, 1'b0);
      end
      ifla_pkg::OP_EXT_W1: begin
        wr_en = 1'b1;
        wr_idx = {2'b00, heap_end[BW-1:2]} - BW'(2) + {2'b00, need[BW-1:2]};
        wr_data = mk_tag(need, 1'b0);
      end
      ifla_pkg::OP_EXT_W2: begin
        wr_en = 1'b1; wr_idx = ((heap_end + need) >> 2) - ONE;
        wr_data = mk_tag('0, 1'b1);
      end
      ifla_pkg::OP_M_RD_NEXT: rd_idx = hdr + {2'b00, rd_size[BW-1:2]};
      ifla_pkg::OP_M_RD_PREV: rd_idx = hdr - ONE;
      ifla_pkg::OP_M_W0: begin
        wr_en = 1'b1; wr_idx = start_w; wr_data = mk_tag(total, 1'b0);
      end
      ifla_pkg::OP_M_W1: begin
        wr_en = 1'b1; wr_idx = start_w + {2'b00, total[BW-1:2]} - ONE;
        wr_data = mk_tag(total, 1'b0);
      end
      ifla_pkg::OP_S_W0: begin
        wr_en = 1'b1; wr_idx = hdr; wr_data = mk_tag(need, 1'b1);
      end
      ifla_pkg::OP_S_W1: begin
        wr_en = 1'b1; wr_idx = hdr + {2'b00, need[BW-1:2]} - ONE;
        wr_data = mk_tag(need, 1'b1);
      end
      ifla_pkg::OP_S_W2: begin
        wr_en = 1'b1; wr_idx = hdr + {2'b00, need[BW-1:2]};
        wr_data = mk_tag(fsize - need, 1'b0);
      end
      ifla_pkg::OP_S_W3: begin
        wr_en = 1'b1; wr_idx = hdr + {2'b00, fsize[BW-1:2]} - ONE;
        wr_data = mk_tag(fsize - need, 1'b0);
      end
      ifla_pkg::OP_A_W0: begin
        wr_en = 1'b1; wr_idx = hdr; wr_data = mk_tag(fsize, 1'b1);
      end
      ifla_pkg::OP_A_W1: begin
        wr_en = 1'b1; wr_idx = hdr + {2'b00, fsize[BW-1:2]} - ONE;
        wr_data = mk_tag(fsize, 1'b1);
      end
      ifla_pkg::OP_FREE_W0: begin
        wr_en = 1'b1; wr_idx = hdr; wr_data = mk_tag(fsize, 1'b0);
      end
      ifla_pkg::OP_FREE_W1: begin
        wr_en = 1'b1; wr_idx = hdr + {2'b00, fsize[BW-1:2]} - ONE;
        wr_data = mk_tag(fsize, 1'b0);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Word store: one write and one registered read per cycle; out-of-range reads give zero.
  always_ff @(posedge clk) begin
    if (wr_en && wr_idx < HW_C) begin
      mem[wr_idx[IW-1:0]] <= wr_data;
    end
    mem_q  <= mem[rd_idx[IW-1:0]];
    rd_oob <= (rd_idx >= HW_C);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iidx     <= '0;
      heap_end <= BW'(INIT_END);
      done     <= 1'b0;
    end else begin
      done <= (op == ifla_pkg::OP_DONE_OK) || (op == ifla_pkg::OP_DONE_FAIL) ||
              (op == ifla_pkg::OP_DONE_FREE);
      case (op)
        ifla_pkg::OP_INIT_WR: iidx <= iidx + IW'(1);
        ifla_pkg::OP_LOAD: begin
          action_q <= action;
          addr_q   <= block_address;
          need     <= BW'(w1) + BW'(8);
          bp       <= BW'(16);
        end
        ifla_pkg::OP_WALK_STEP: bp <= bp + rd_size;
        ifla_pkg::OP_EXT_W2: begin
          bp       <= heap_end;
          heap_end <= heap_end + need;
        end
        ifla_pkg::OP_M_RD_NEXT: msize <= rd_size;
        ifla_pkg::OP_M_RD_PREV: begin
          nsize <= rd_size;
          nfree <= ~rdata[0];
        end
        ifla_pkg::OP_M_CALC: begin
          start_w <= pfree ? hdr - {2'b00, psize[BW-1:2]} : hdr;
          total   <= msize + (nfree ? nsize : '0) + (pfree ? psize : '0);
        end
        ifla_pkg::OP_M_W1: bp <= (start_w + ONE) << 2;
        ifla_pkg::OP_F_CALC, ifla_pkg::OP_FREE_CAP: fsize <= rd_size;
        ifla_pkg::OP_S_W3: fsize <= need;
        ifla_pkg::OP_DONE_OK: begin
          payload_address <= bp[13:0];
          granted_bytes   <= fsize[14:0];
          status          <= 1'b0;
        end
        ifla_pkg::OP_DONE_FAIL: begin
          payload_address <= '0;
          granted_bytes   <= '0;
          status          <= 1'b1;
        end
        ifla_pkg::OP_DONE_FREE: begin
          payload_address <= '0;
          granted_bytes   <= '0;
          status          <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    st.init_last  = (BW'(iidx) == HW_C - ONE);
    st.is_free    = action_q;
    st.bp_in      = {2'b00, bp[BW-1:2]} < HW_C;
    st.bp_le_addr = bp <= BW'(addr_q);
    st.bp_is_addr = bp == BW'(addr_q);
    st.rd_zero    = rd_size == '0;
    st.rd_alloc   = rdata[0];
    st.rd_fit     = rd_size >= need;
    st.no_room    = (heap_end + need) > LIMIT;
    st.split      = (fsize >= need) && ((fsize - need) > MIN_REM);
  end

endmodule

`default_nettype wire

>>> hdl/ifla_ctrl.sv
// Sequencing state machine of the allocator.
// Issues one ifla_pkg operation code per cycle to ifla_dp and reads its status.
`default_nettype none

module ifla_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire ifla_pkg::dp_status_t st,
  input  wire logic                 action,
  output logic                      busy,
  output ifla_pkg::op_t             op
);

  localparam logic [4:0] S_INIT    = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_AW_RD   = 5'd2;
  localparam logic [4:0] S_AW_CHK  = 5'd3;
  localparam logic [4:0] S_EXT     = 5'd4;
  localparam logic [4:0] S_EXT1    = 5'd5;
  localparam logic [4:0] S_EXT2    = 5'd6;
  localparam logic [4:0] S_M_HDR   = 5'd7;
  localparam logic [4:0] S_M_NEXT  = 5'd8;
  localparam logic [4:0] S_M_PREV  = 5'd9;
  localparam logic [4:0] S_M_CALC  = 5'd10;
  localparam logic [4:0] S_M_W0    = 5'd11;
  localparam logic [4:0] S_M_W1    = 5'd12;
  localparam logic [4:0] S_FIN_RD  = 5'd13;
  localparam logic [4:0] S_FIN_SZ  = 5'd14;
  localparam logic [4:0] S_FIN_W0  = 5'd15;
  localparam logic [4:0] S_SPL1    = 5'd16;
  localparam logic [4:0] S_SPL2    = 5'd17;
  localparam logic [4:0] S_SPL3    = 5'd18;
  localparam logic [4:0] S_ALC1    = 5'd19;
  localparam logic [4:0] S_DONE_OK = 5'd20;
  localparam logic [4:0] S_FW_RD   = 5'd21;
  localparam logic [4:0] S_FW_CHK  = 5'd22;
  localparam logic [4:0] S_FR_W0   = 5'd23;
  localparam logic [4:0] S_FR_W1   = 5'd24;
  localparam logic [4:0] S_DONE_FR = 5'd25;

  logic [4:0] state, state_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = ifla_pkg::OP_NOP;
    case (state)
      S_INIT: begin
        op = ifla_pkg::OP_INIT_WR;
        if (st.init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          op = ifla_pkg::OP_LOAD;
          state_next = action ? S_FW_RD : S_AW_RD;
        end
      end
      S_AW_RD: begin
        if (!st.bp_in) begin
          state_next = S_EXT;
        end else begin
          op = ifla_pkg::OP_WALK_RD;
          state_next = S_AW_CHK;
        end
      end
      S_AW_CHK: begin
        if (st.rd_zero) begin
          state_next = S_EXT;
        end else if (!st.rd_alloc && st.rd_fit) begin
          state_next = S_FIN_RD;
        end else begin
          op = ifla_pkg::OP_WALK_STEP;
          state_next = S_AW_RD;
        end
      end
      S_EXT: begin
        if (st.no_room) begin
          op = ifla_pkg::OP_DONE_FAIL;
          state_next = S_IDLE;
        end else begin
          op = ifla_pkg::OP_EXT_W0;
          state_next = S_EXT1;
        end
      end
      S_EXT1: begin
        op = ifla_pkg::OP_EXT_W1;
        state_next = S_EXT2;
      end
      S_EXT2: begin
        op = ifla_pkg::OP_EXT_W2;
        state_next = S_M_HDR;
      end
      S_M_HDR: begin
        op = ifla_pkg::OP_M_RD_HDR;
        state_next = S_M_NEXT;
      end
      S_M_NEXT: begin
        op = ifla_pkg::OP_M_RD_NEXT;
        state_next = S_M_PREV;
      end
      S_M_PREV: begin
        op = ifla_pkg::OP_M_RD_PREV;
        state_next = S_M_CALC;
      end
      S_M_CALC: begin
        op = ifla_pkg::OP_M_CALC;
        state_next = S_M_W0;
      end
      S_M_W0: begin
        op = ifla_pkg::OP_M_W0;
        state_next = S_M_W1;
      end
      S_M_W1: begin
        op = ifla_pkg::OP_M_W1;
        state_next = st.is_free ? S_DONE_FR : S_FIN_RD;
      end
      S_FIN_RD: begin
        op = ifla_pkg::OP_F_RD;
        state_next = S_FIN_SZ;
      end
      S_FIN_SZ: begin
        op = ifla_pkg::OP_F_CALC;
        state_next = S_FIN_W0;
      end
      S_FIN_W0: begin
        if (st.split) begin
          op = ifla_pkg::OP_S_W0;
          state_next = S_SPL1;
        end else begin
          op = ifla_pkg::OP_A_W0;
          state_next = S_ALC1;
        end
      end
      S_SPL1: begin
        op = ifla_pkg::OP_S_W1;
        state_next = S_SPL2;
      end
      S_SPL2: begin
        op = ifla_pkg::OP_S_W2;
        state_next = S_SPL3;
      end
      S_SPL3: begin
        op = ifla_pkg::OP_S_W3;
        state_next = S_DONE_OK;
      end
      S_ALC1: begin
        op = ifla_pkg::OP_A_W1;
        state_next = S_DONE_OK;
      end
      S_DONE_OK: begin
        op = ifla_pkg::OP_DONE_OK;
        state_next = S_IDLE;
      end
      S_FW_RD: begin
        if (!(st.bp_in && st.bp_le_addr)) begin
          state_next = S_DONE_FR;
        end else begin
          op = ifla_pkg::OP_WALK_RD;
          state_next = S_FW_CHK;
        end
      end
      S_FW_CHK: begin
        if (st.rd_zero) begin
          state_next = S_DONE_FR;
        end else if (st.bp_is_addr) begin
          if (st.rd_alloc) begin
            op = ifla_pkg::OP_FREE_CAP;
            state_next = S_FR_W0;
          end else begin
            state_next = S_DONE_FR;
          end
        end else begin
          op = ifla_pkg::OP_WALK_STEP;
          state_next = S_FW_RD;
        end
      end
      S_FR_W0: begin
        op = ifla_pkg::OP_FREE_W0;
        state_next = S_FR_W1;
      end
      S_FR_W1: begin
        op = ifla_pkg::OP_FREE_W1;
        state_next = S_M_HDR;
      end
      S_DONE_FR: begin
        op = ifla_pkg::OP_DONE_FREE;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_init_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_INIT && !st.init_last) |=> state == S_INIT)
    else $error("store initialization left early");
  a_start_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> (state == S_AW_RD || state == S_FW_RD))
    else $error("accepted item did not begin a walk");
  a_merge_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_M_W1 && st.is_free) |=> state == S_DONE_FR)
    else $error("free did not finish after coalescing");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE_OK || state == S_DONE_FR) |=> state == S_IDLE)
    else $error("result state did not return to idle");
`endif

endmodule

`default_nettype wire

>>> hdl/implicit_free_list_allocator_top.sv
// Top level of the first-fit boundary-tag heap allocator.
// Joins ifla_ctrl and ifla_dp; both use ifla_pkg.
//
//   channel   handshake          payload
//   input     start / busy       action, request_bytes, block_address
//   result    done (one cycle)   payload_address, granted_bytes, status
//
// After reset the block writes the initial heap layout into every word of the
// word store, with busy high. An item is taken when start is high and busy is
// low. The first-fit walk reads one header at a time through the single store
// read port, in a read state and then a check state. The result is shown for
// one cycle on done and cannot be stalled; busy is low in that cycle.
`default_nettype none

module implicit_free_list_allocator_top #(
  parameter int HEAP_WORDS          = 4096,
  parameter int INITIAL_CHUNK_BYTES = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        action,
  input  wire logic [14:0] request_bytes,
  input  wire logic [13:0] block_address,
  output logic             done,
  output logic [13:0]      payload_address,
  output logic [14:0]      granted_bytes,
  output logic             status
);

  // Command and status between the sequencer and the datapath.
  ifla_pkg::op_t        op;
  ifla_pkg::dp_status_t st;

  ifla_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .st     (st),
    .action (action),
    .busy   (busy),
    .op     (op)
  );

  // The datapath captures the item fields when it sees the load operation.
  ifla_dp #(
    .HEAP_WORDS          (HEAP_WORDS),
    .INITIAL_CHUNK_BYTES (INITIAL_CHUNK_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .action          (action),
    .request_bytes   (request_bytes),
    .block_address   (block_address),
    .st              (st),
    .done            (done),
    .payload_address (payload_address),
    .granted_bytes   (granted_bytes),
    .status          (status)
  );

endmodule

`default_nettype wire

>>> sim/tb_implicit_free_list_allocator_top.sv
// Self-checking testbench for the first-fit boundary-tag heap allocator.
// Depends on hdl/implicit_free_list_allocator_top.sv, its submodules and their package.
// A local heap image predicts each result, and the checker compares every done pulse.
`default_nettype none

module tb_implicit_free_list_allocator_top;

  localparam int HEAP_WORDS  = 4096;
  localparam int LIMIT_BYTES = HEAP_WORDS * 4;
  localparam int FIRST_BP    = 16;
  localparam bit ACT_ALLOC   = 1'b0;
  localparam bit ACT_FREE    = 1'b1;
  localparam bit ST_OK       = 1'b0;
  localparam bit ST_NO_SPACE = 1'b1;

  typedef struct {
    logic [13:0] addr;
    logic [14:0] bytes;
    logic        st;
  } grant_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        action;
  logic [14:0] request_bytes;
  logic [13:0] block_address;
  logic        done;
  logic [13:0] payload_address;
  logic [14:0] granted_bytes;
  logic        status;

  // Local copy of the word store and the heap end.
  logic [31:0] heap_img [HEAP_WORDS];
  int unsigned heap_top;

  // Expected results in issue order, and payloads currently allocated.
  grant_t      pending_grants[$];
  int unsigned live_blocks[$];

  int errors;
  int n_alloc_ok;
  int n_alloc_fail;
  int n_free;
  int idle_pct;

  implicit_free_list_allocator_top u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .action          (action),
    .request_bytes   (request_bytes),
    .block_address   (block_address),
    .done            (done),
    .payload_address (payload_address),
    .granted_bytes   (granted_bytes),
    .status          (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Heap image helpers. Reads past the store give zero, writes past it drop.
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] img_rd(int unsigned idx);
    if (idx >= HEAP_WORDS) return 32'd0;
    return heap_img[idx];
  endfunction

  function automatic void img_wr(int unsigned idx, logic [31:0] v);
    if (idx < HEAP_WORDS) heap_img[idx] = v;
  endfunction

  function automatic logic [31:0] tag(int unsigned sz, bit alloc);
    return (sz << 3) | alloc;
  endfunction

  function automatic void img_reset();
    for (int i = 0; i < HEAP_WORDS; i++) heap_img[i] = 32'd0;
    img_wr(0, tag(0, 1));
    img_wr(1, tag(8, 1));
    img_wr(2, tag(8, 1));
    // One free 520-byte block behind the prologue, then the epilogue.
    img_wr(3, tag(520, 0));
    img_wr(3 + 520 / 4 - 1, tag(520, 0));
    img_wr(3 + 520 / 4, tag(0, 1));
    heap_top = FIRST_BP + 520;
  endfunction

  // Joins the free block at payload bp with free neighbors on both sides.
  function automatic int unsigned coalesce(int unsigned bp);
    int unsigned hdr, sz, total, first;
    logic [31:0] nxt, prv;
    hdr   = bp / 4 - 1;
    sz    = img_rd(hdr) >> 3;
    nxt   = img_rd(hdr + sz / 4);
    prv   = img_rd(hdr - 1);
    first = hdr;
    total = sz;
    if (nxt[0] == 1'b0) total += nxt >> 3;
    if (prv[0] == 1'b0) begin
      first = hdr - (prv >> 3) / 4;
      total += prv >> 3;
    end
    img_wr(first, tag(total, 0));
    img_wr(first + total / 4 - 1, tag(total, 0));
    return (first + 1) * 4;
  endfunction

  function automatic grant_t grant_block(int unsigned req);
    grant_t      g;
    int unsigned w, need, bp, sz, fsize, hdr, rem, nb;
    logic [31:0] t;
    bit          hit;
    g.addr  = '0;
    g.bytes = '0;
    g.st    = ST_OK;
    w    = (req < 8) ? 8 : req;
    w    = (w + 7) & ~32'd7;
    need = w + 8;
    bp   = FIRST_BP;
    hit  = 1'b0;
    while (bp / 4 < HEAP_WORDS) begin
      t  = img_rd(bp / 4 - 1);
      sz = t >> 3;
      if (sz == 0) break;
      if (t[0] == 1'b0 && sz >= need) begin
        hit = 1'b1;
        break;
      end
      bp += sz;
    end
    if (!hit) begin
      nb = heap_top;
      if (nb + need > LIMIT_BYTES || nb < FIRST_BP) begin
        g.st = ST_NO_SPACE;
        return g;
      end
      img_wr(nb / 4 - 1, tag(need, 0));
      img_wr(nb / 4 - 2 + need / 4, tag(need, 0));
      img_wr((nb + need) / 4 - 1, tag(0, 1));
      heap_top = nb + need;
      bp = coalesce(nb);
    end
    hdr   = bp / 4 - 1;
    fsize = img_rd(hdr) >> 3;
    if (fsize >= need && fsize - need > 16) begin
      rem = fsize - need;
      img_wr(hdr, tag(need, 1));
      img_wr(hdr + need / 4 - 1, tag(need, 1));
      img_wr(hdr + need / 4, tag(rem, 0));
      img_wr(hdr + fsize / 4 - 1, tag(rem, 0));
      fsize = need;
    end else begin
      img_wr(hdr, tag(fsize, 1));
      img_wr(hdr + fsize / 4 - 1, tag(fsize, 1));
    end
    g.addr  = bp[13:0];
    g.bytes = fsize[14:0];
    return g;
  endfunction

  // Returns 1 when the address named an allocated block and it was released.
  function automatic bit release_block(int unsigned addr);
    int unsigned bp, sz, hdr;
    logic [31:0] t;
    bit          hit;
    bp  = FIRST_BP;
    hit = 1'b0;
    while (bp / 4 < HEAP_WORDS && bp <= addr) begin
      t  = img_rd(bp / 4 - 1);
      sz = t >> 3;
      if (sz == 0) break;
      if (bp == addr) begin
        hit = t[0];
        break;
      end
      bp += sz;
    end
    if (hit) begin
      hdr = bp / 4 - 1;
      sz  = img_rd(hdr) >> 3;
      img_wr(hdr, tag(sz, 0));
      img_wr(hdr + sz / 4 - 1, tag(sz, 0));
      void'(coalesce(bp));
    end
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Item sender. Inputs change on the falling edge; busy is looked at there,
  // so the item is taken at the following rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(bit act, int unsigned req, int unsigned addr);
    grant_t g;
    @(negedge clk);
    start         = 1'b1;
    action        = act;
    request_bytes = req[14:0];
    block_address = addr[13:0];
    while (busy) @(negedge clk);
    @(posedge clk);
    g.addr  = '0;
    g.bytes = '0;
    g.st    = ST_OK;
    if (act == ACT_ALLOC) begin
      g = grant_block(req[14:0]);
      if (g.st == ST_OK) begin
        live_blocks.push_back(g.addr);
        n_alloc_ok++;
      end else begin
        n_alloc_fail++;
      end
    end else begin
      if (release_block(addr[13:0])) begin
        foreach (live_blocks[i]) begin
          if (live_blocks[i] == addr[13:0]) begin
            live_blocks.delete(i);
            break;
          end
        end
      end
      n_free++;
    end
    pending_grants.push_back(g);
  endtask

  // Holds start low at random, with the chance in percent given by idle_pct.
  task automatic maybe_idle();
    int n;
    if ($urandom_range(99) < idle_pct) begin
      n = $urandom_range(1, 6);
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_grants.size() != 0) @(negedge clk);
  endtask

  task automatic free_live(int idx);
    send_item(ACT_FREE, $urandom_range(32767), live_blocks[idx]);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every done pulse is matched to the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    grant_t g;
    if (!rst && done) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        g = pending_grants.pop_front();
        if (payload_address !== g.addr)
          report_mismatch($sformatf("payload_address %0d, expected %0d",
                                    payload_address, g.addr));
        if (granted_bytes !== g.bytes)
          report_mismatch($sformatf("granted_bytes %0d, expected %0d",
                                    granted_bytes, g.bytes));
        if (status !== g.st)
          report_mismatch($sformatf("status %0d, expected %0d", status, g.st));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Smallest requests round to an 8-byte payload; odd sizes round up.
  task automatic test_rounding();
    send_item(ACT_ALLOC, 0, 0);
    send_item(ACT_ALLOC, 1, 16383);
    send_item(ACT_ALLOC, 8, 0);
    send_item(ACT_ALLOC, 9, 0);
    send_item(ACT_ALLOC, 23, 0);
  endtask

  // Releasing neighbors in an order that exercises joins on each side.
  task automatic test_coalesce();
    send_item(ACT_FREE, 0, live_blocks[1]);
    send_item(ACT_FREE, 0, live_blocks[2]);
    send_item(ACT_FREE, 0, live_blocks[0]);
    send_item(ACT_FREE, 0, live_blocks[0]);
  endtask

  // Bad releases: odd address, a tag word, a block freed twice, past the heap, zero.
  task automatic test_bad_free();
    send_item(ACT_FREE, 0, 17);
    send_item(ACT_FREE, 0, 12);
    send_item(ACT_FREE, 0, FIRST_BP);
    send_item(ACT_FREE, 0, 16383);
    send_item(ACT_FREE, 0, 0);
  endtask

  // A request with no fitting block grows the heap and joins the free tail.
  task automatic test_grow();
    send_item(ACT_ALLOC, 1000, 0);
    send_item(ACT_ALLOC, 496, 0);
    send_item(ACT_ALLOC, 6000, 0);
  endtask

  // Oversized requests and a full store report no space without changes.
  task automatic test_no_space();
    send_item(ACT_ALLOC, 16384, 0);
    send_item(ACT_ALLOC, 16376, 0);
    send_item(ACT_ALLOC, 9000, 0);
    send_item(ACT_ALLOC, 9000, 0);
    while (live_blocks.size() != 0) free_live(0);
  endtask

  // Mostly real allocate and release traffic with random sizes, plus noise.
  task automatic test_random(int count);
    int unsigned sel, req;
    for (int i = 0; i < count; i++) begin
      idle_pct = (i >= 700 && i < 1000) ? 0 : 29;
      if (i == 400) drain_results();
      sel = $urandom_range(99);
      if (sel < 48) begin
        req = $urandom_range(99);
        if (req < 80)      req = $urandom_range(600);
        else if (req < 96) req = $urandom_range(4096);
        else               req = $urandom_range(16384);
        send_item(ACT_ALLOC, req, $urandom_range(16383));
      end else if (sel < 88 && live_blocks.size() != 0) begin
        free_live($urandom_range(live_blocks.size() - 1));
      end else begin
        send_item(ACT_FREE, $urandom_range(16384), $urandom_range(16383));
      end
      maybe_idle();
    end
  endtask

  initial begin
    errors        = 0;
    n_alloc_ok    = 0;
    n_alloc_fail  = 0;
    n_free        = 0;
    idle_pct      = 0;
    rst           = 1'b1;
    start         = 1'b0;
    action        = 1'b0;
    request_bytes = '0;
    block_address = '0;
    img_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_rounding();
    test_coalesce();
    test_bad_free();
    test_grow();
    test_no_space();
    test_random(2000);

    drain_results();
    repeat (2500) @(posedge clk);
    $display("Covered %0d grants, %0d no-space refusals and %0d free requests,",
             n_alloc_ok, n_alloc_fail, n_free);
    $display("including splits, heap growth, joins and bad release addresses.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Timeout waiting for the allocator");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
